@@ sv/rcfc_pkg.sv @@
`default_nettype none

package rcfc_pkg;

	localparam int FRAME_BYTES   = 11;
	localparam int PAYLOAD_START = 3;
	localparam int PAY_BYTES     = FRAME_BYTES - PAYLOAD_START;
	localparam int POS_W         = $clog2(FRAME_BYTES + 1);

	localparam logic [15:0] CRC_POLY    = 16'h8005;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [7:0]  BIND_LIMIT  = 8'd130;
	localparam logic [7:0]  COUNT_CLAMP = 8'd131;

	// link quality source codes
	localparam logic [1:0] LQI_SRC_NONE = 2'd0;
	localparam logic [1:0] LQI_SRC_BYTE = 2'd1;
	localparam logic [1:0] LQI_SRC_ZERO = 2'd2;
	localparam logic [1:0] LQI_SRC_RSVD = 2'd3;

	localparam logic [1:0] LQI_SRC_RESET = LQI_SRC_BYTE;

	// register index (paddr word bit)
	localparam logic REG_LQ_SRC = 1'b0;

	localparam int PADDR_W = 3;

	// completed frame handed from the assembler to the unpacker
	typedef struct packed {
		logic                       done;
		logic                       ok;
		logic [7:0]                 hdr;
		logic [PAY_BYTES-1:0][7:0]  pay;
	} frame_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        top;
		r = crc;
		for (int k = 0; k < 8; k++) begin
			top = r[15] ^ b[7-k];
			r = {r[14:0], 1'b0};
			if (top) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/rcfc_cfg.sv @@
`default_nettype none

module rcfc_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rcfc_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output logic      [1:0]                    lq_src
);
	import rcfc_pkg::*;

	logic [1:0] lq_src_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lq_src_q <= LQI_SRC_RESET;
		end else if (wr_en && paddr[2] == REG_LQ_SRC) begin
			lq_src_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_LQ_SRC) begin
			prdata = {30'd0, lq_src_q};
		end
	end

	assign lq_src = lq_src_q;

endmodule

`default_nettype wire

@@ sv/rcfc_assemble.sv @@
`default_nettype none

module rcfc_assemble (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       rx_byte,
	input  wire logic             frame_start,
	input  wire logic             out_free,
	output rcfc_pkg::frame_t      frame
);
	import rcfc_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;
	logic             s1_adv;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [7:0]       store_q [FRAME_BYTES];

	logic [POS_W-1:0] eff_pos;
	logic             in_frame;
	logic [15:0]      crc_base;
	logic [15:0]      crc_new;

	// s1 only moves on when the result register can take whatever it makes
	assign s1_adv   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	always_comb begin
		eff_pos  = start_s1 ? '0 : pos_q;
		in_frame = eff_pos < POS_W'(FRAME_BYTES);
		crc_base = (eff_pos == '0) ? CRC_INIT : crc_q;
		crc_new  = (eff_pos >= POS_W'(PAYLOAD_START)) ? crc16_byte(crc_base, byte_s1) : crc_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
		end else if (s1_adv) begin
			if (in_frame) begin
				pos_q <= eff_pos + POS_W'(1);
				crc_q <= crc_new;
			end else if (start_s1) begin
				crc_q <= CRC_INIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_frame) begin
			store_q[eff_pos] <= byte_s1;
		end
	end

	// last byte comes straight from s1, the rest from the store
	always_comb begin
		frame.done = s1_adv && (eff_pos == POS_W'(FRAME_BYTES - 1));
		frame.ok   = crc_new == {store_q[1], store_q[2]};
		frame.hdr  = store_q[0];
		for (int i = 0; i < PAY_BYTES - 1; i++) begin
			frame.pay[i] = store_q[PAYLOAD_START + i];
		end
		frame.pay[PAY_BYTES-1] = byte_s1;
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(FRAME_BYTES))
		else $error("byte position beyond frame length");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty s1");

	a_done_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |=> pos_q == POS_W'(FRAME_BYTES))
		else $error("frame end did not park position");

endmodule

`default_nettype wire

@@ sv/rcfc_unpack.sv @@
`default_nettype none

module rcfc_unpack (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rcfc_pkg::frame_t  frame,
	input  wire logic [1:0]        lq_src,
	output logic                   out_free,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   crc_ok,
	output logic                   packet_lost,
	output logic [10:0]            stick_0,
	output logic [10:0]            stick_1,
	output logic [10:0]            stick_2,
	output logic [10:0]            stick_3,
	output logic [11:0]            aux_bits,
	output logic                   lqi_valid,
	output logic [7:0]             lqi_value,
	output logic                   link_ready,
	output logic                   bind_mode
);
	import rcfc_pkg::*;

	logic        out_valid_q;
	logic [7:0]  cnt_q;
	logic        ready_q;
	logic        bind_q;

	logic        crc_ok_q;
	logic        lost_q;
	logic [10:0] stick0_q, stick1_q, stick2_q, stick3_q;
	logic [11:0] aux_q;
	logic        lqi_valid_q;
	logic [7:0]  lqi_value_q;

	logic        lost;
	logic        chan_ok;
	logic [7:0]  cnt_inc;
	logic [7:0]  cnt_nxt;
	logic        ready_nxt;
	logic        bind_nxt;
	logic        lq_ok;
	logic [7:0]  lq_val;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		lost    = frame.ok && (frame.hdr[7:6] == 2'b01);
		chan_ok = frame.ok && !lost;
		cnt_inc = cnt_q + 8'd1;

		cnt_nxt   = cnt_q;
		ready_nxt = ready_q;
		bind_nxt  = bind_q;
		if (chan_ok) begin
			cnt_nxt = cnt_inc;
			if (cnt_inc < BIND_LIMIT) begin
				bind_nxt = 1'b1;
			end
		end
		// only a fresh increment can pass the clamp
		if (frame.ok && cnt_nxt > COUNT_CLAMP) begin
			ready_nxt = 1'b1;
			bind_nxt  = 1'b0;
			cnt_nxt   = COUNT_CLAMP;
		end

		lq_ok  = 1'b0;
		lq_val = '0;
		unique case (lq_src)
			LQI_SRC_BYTE: begin
				lq_ok  = frame.ok;
				lq_val = frame.ok ? frame.pay[7] : 8'd0;
			end
			LQI_SRC_ZERO: begin
				lq_ok = frame.ok;
			end
			LQI_SRC_NONE, LQI_SRC_RSVD: begin
				lq_ok = 1'b0;
			end
			default: begin
				lq_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			ready_q     <= 1'b0;
			bind_q      <= 1'b0;
		end else begin
			if (frame.done) begin
				out_valid_q <= 1'b1;
				cnt_q       <= cnt_nxt;
				ready_q     <= ready_nxt;
				bind_q      <= bind_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame.done) begin
			crc_ok_q    <= frame.ok;
			lost_q      <= lost;
			stick0_q    <= chan_ok ? {frame.pay[1][2:0], frame.pay[0]} : 11'd0;
			stick1_q    <= chan_ok ? {frame.pay[2][6:0], frame.pay[1][7:4]} : 11'd0;
			stick2_q    <= chan_ok ? {frame.pay[4][2:0], frame.pay[3]} : 11'd0;
			stick3_q    <= chan_ok ? {frame.pay[5][6:0], frame.pay[4][7:4]} : 11'd0;
			aux_q       <= chan_ok ? {frame.pay[6], frame.pay[5][7], frame.pay[4][3],
			                          frame.pay[2][7], frame.pay[1][3]} : 12'd0;
			lqi_valid_q <= lq_ok;
			lqi_value_q <= lq_val;
		end
	end

	assign out_valid   = out_valid_q;
	assign crc_ok      = crc_ok_q;
	assign packet_lost = lost_q;
	assign stick_0     = stick0_q;
	assign stick_1     = stick1_q;
	assign stick_2     = stick2_q;
	assign stick_3     = stick3_q;
	assign aux_bits    = aux_q;
	assign lqi_valid   = lqi_valid_q;
	assign lqi_value   = lqi_value_q;
	assign link_ready  = ready_q;
	assign bind_mode   = bind_q;

	a_cnt_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_CLAMP)
		else $error("good frame count above clamp");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |=> ready_q)
		else $error("ready flag dropped");

	a_ready_no_bind: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> !bind_q)
		else $error("bind indication while ready");

endmodule

`default_nettype wire

@@ sv/rc_frame_crc_check_and_unpack.sv @@
// Radio-control frame checker and unpacker.
// Input channel (in_valid / in_stall): one frame byte per request, rx_byte with
// frame_start marking byte 0. Eleven bytes make a frame; CRC-16 (poly 0x8005,
// init 0xFFFF) runs over bytes 3..10 and is checked against bytes 1..2.
// Output channel (out_valid / out_stall): one request per completed frame with
// crc status, lost flag, four sticks, aux bits, link quality and link state.
// Bytes arriving after byte 10 without frame_start give no output.
// The result of byte 10 passes two registers: the accepting edge loads the input
// register, and the result register loads once it is free. Throughput is one
// byte per cycle while the receiver does not stall; the bytewise CRC update
// between the two registers sets it.
// When the receiver stalls, the result register holds; once a byte sits in the
// input register, in_stall rises in the same cycle and stays until the result
// is taken.
// Reset: byte position 0, CRC 0xFFFF, good-frame count 0, ready and bind flags
// clear, lq_src 1. Register lq_src lives at address 0 of the APB port. The user
// must write it only while no frame is in flight; the block doesn't check it.
`default_nettype none

module rc_frame_crc_check_and_unpack (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rcfc_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    rx_byte,
	input  wire logic                          frame_start,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               crc_ok,
	output logic                               packet_lost,
	output logic      [10:0]                   stick_0,
	output logic      [10:0]                   stick_1,
	output logic      [10:0]                   stick_2,
	output logic      [10:0]                   stick_3,
	output logic      [11:0]                   aux_bits,
	output logic                               lqi_valid,
	output logic      [7:0]                    lqi_value,
	output logic                               link_ready,
	output logic                               bind_mode
);
	import rcfc_pkg::*;

	logic [1:0] lq_src;
	logic       out_free;
	frame_t     frame;

	rcfc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.lq_src     (lq_src)
	);

	rcfc_assemble u_assemble (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.out_free    (out_free),
		.frame       (frame)
	);

	rcfc_unpack u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame),
		.lq_src      (lq_src),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.crc_ok      (crc_ok),
		.packet_lost (packet_lost),
		.stick_0     (stick_0),
		.stick_1     (stick_1),
		.stick_2     (stick_2),
		.stick_3     (stick_3),
		.aux_bits    (aux_bits),
		.lqi_valid   (lqi_valid),
		.lqi_value   (lqi_value),
		.link_ready  (link_ready),
		.bind_mode   (bind_mode)
	);

endmodule

`default_nettype wire
